// ===== rtl/bsp_pkg.sv =====
// Package for the bounding sphere block: sizes and widths.
// No dependencies.
`default_nettype none
package bsp_pkg;
    localparam int MaxPoints = 1024;
    localparam int AddrW     = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);
    localparam int CoordW    = 16;
    localparam int PointW    = 3 * CoordW;
    localparam int SumW      = CoordW + AddrW + 1;
    localparam int DiffW     = CoordW + 2;
    localparam int DistW     = 2 * DiffW + 2;
    localparam int RadW      = DistW / 2;
endpackage
`default_nettype wire

// ===== rtl/bsp_ram.sv =====
// Generic single-port write, single-port read RAM with registered read data.
// No dependencies.
`default_nettype none
module bsp_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/bounding_sphere_from_points.sv =====
// Average-center bounding sphere over a set of Q8.8 points.
// Loading takes one cycle per point word; the input is held off from the last point until
// the result word is taken. After the last point, three serial dividers run, then a pass
// reads one stored point per cycle, then a serial square root runs, and the result waits
// for tready. Reset (synchronous, active low) clears control and accumulators; the point
// memory is not cleared, as only entries written in the current set are read.
`default_nettype none
module bounding_sphere_from_points
    import bsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: point_x[15:0], point_y[31:16], point_z[47:32]
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: center_x[15:0], center_y[31:16], center_z[47:32], radius[64:48]
    output logic [71:0]      m_axis_tdata
);
    localparam logic [2:0] S_LOAD = 3'd0, S_DIV = 3'd1, S_PASS = 3'd2,
                           S_SQRT = 3'd3, S_OUT = 3'd4;
    localparam int DivCntW = $clog2(SumW + 1);
    localparam int SqCntW  = $clog2(RadW + 1);

    logic [2:0]         r_state;
    logic [CntW-1:0]    r_count;
    logic signed [SumW-1:0] r_sum [3];
    // Divider: magnitude quotient and partial remainder per axis.
    logic [SumW-1:0]    r_quo [3];
    logic [SumW-1:0]    r_rem [3];
    logic [DivCntW-1:0] r_dcnt;
    logic signed [CoordW-1:0] r_ctr [3];
    // Pass: read address, read data valid, squares valid.
    logic [CntW-1:0]    r_raddr;
    logic               r_pv;
    logic [DiffW*2-1:0] r_sq [3];
    logic               r_sqv;
    logic [DistW-1:0]   r_max;
    // Square root (one result bit per cycle).
    logic [DistW-1:0]   r_rad_rem;
    logic [RadW-1:0]    r_root;
    logic [SqCntW-1:0]  r_scnt;
    logic [DistW-1:0]   r_val;
    logic [PointW-1:0]  w_rdata;
    logic               w_acc, w_we;

    assign s_axis_tready = (r_state == S_LOAD);
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_we  = w_acc && (r_count < CntW'(MaxPoints));

    bsp_ram #(.Width(PointW), .Depth(MaxPoints)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[AddrW-1:0]),
        .i_wdata(s_axis_tdata),
        .i_raddr(r_raddr[AddrW-1:0]),
        .o_rdata(w_rdata)
    );

    // Restoring square root step over the DistW-bit maximum.
    logic [DistW-1:0] w_trial;
    logic [DistW-1:0] w_cur;
    always_comb begin
        w_cur   = {r_rad_rem[DistW-3:0], r_val[DistW-1 -: 2]};
        w_trial = {r_root, 2'b01} & {DistW{1'b1}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_sum[0] <= '0; r_sum[1] <= '0; r_sum[2] <= '0;
            r_pv    <= 1'b0;
            r_sqv   <= 1'b0;
            r_max   <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        logic [CntW-1:0] nc;
                        nc = w_we ? r_count + 1'b1 : r_count;
                        if (w_we) begin
                            for (int a = 0; a < 3; a++)
                                r_sum[a] <= r_sum[a] + SumW'($signed(
                                    s_axis_tdata[a*CoordW +: CoordW]));
                        end
                        r_count <= nc;
                        if (s_axis_tlast) begin
                            r_state <= S_DIV;
                            r_dcnt  <= '0;
                            for (int a = 0; a < 3; a++) begin
                                logic signed [SumW-1:0] s;
                                s = w_we ? r_sum[a] + SumW'($signed(
                                    s_axis_tdata[a*CoordW +: CoordW])) : r_sum[a];
                                r_quo[a] <= s[SumW-1] ? -s : s;
                                r_rem[a] <= '0;
                            end
                        end
                    end
                end
                S_DIV: begin
                    for (int a = 0; a < 3; a++) begin
                        logic [SumW:0] t;
                        t = {r_rem[a], r_quo[a][SumW-1]};
                        if (t >= (SumW+1)'(r_count)) begin
                            r_rem[a] <= SumW'(t - (SumW+1)'(r_count));
                            r_quo[a] <= {r_quo[a][SumW-2:0], 1'b1};
                        end else begin
                            r_rem[a] <= t[SumW-1:0];
                            r_quo[a] <= {r_quo[a][SumW-2:0], 1'b0};
                        end
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DivCntW'(SumW)) begin
                        for (int a = 0; a < 3; a++) begin
                            logic [SumW-1:0] q;
                            q = r_sum[a][SumW-1] ? -r_quo[a] : r_quo[a];
                            r_ctr[a] <= q[CoordW-1:0];
                        end
                        r_state <= S_PASS;
                        r_raddr <= '0;
                        r_max   <= '0;
                        r_pv    <= 1'b0;
                        r_sqv   <= 1'b0;
                    end
                end
                S_PASS: begin
                    // Read data is valid in the cycle after its address was issued.
                    r_pv <= r_raddr < r_count;
                    if (r_raddr < r_count) r_raddr <= r_raddr + 1'b1;
                    r_sqv <= r_pv;
                    if (r_pv) begin
                        for (int a = 0; a < 3; a++) begin
                            logic signed [DiffW-1:0] d;
                            logic [DiffW-1:0] m;
                            d = DiffW'($signed(w_rdata[a*CoordW +: CoordW]))
                                - DiffW'(r_ctr[a]);
                            m = d[DiffW-1] ? -d : d;
                            r_sq[a] <= m * m;
                        end
                    end
                    if (r_sqv) begin
                        logic [DistW-1:0] s2;
                        s2 = DistW'(r_sq[0]) + DistW'(r_sq[1]) + DistW'(r_sq[2]);
                        if (s2 > r_max) r_max <= s2;
                    end
                    if (!r_pv && !r_sqv && r_raddr == r_count) begin
                        r_state   <= S_SQRT;
                        r_val     <= r_max;
                        r_rad_rem <= '0;
                        r_root    <= '0;
                        r_scnt    <= '0;
                    end
                end
                S_SQRT: begin
                    if (w_cur >= w_trial) begin
                        r_rad_rem <= w_cur - w_trial;
                        r_root    <= {r_root[RadW-2:0], 1'b1};
                    end else begin
                        r_rad_rem <= w_cur;
                        r_root    <= {r_root[RadW-2:0], 1'b0};
                    end
                    r_val  <= {r_val[DistW-3:0], 2'b00};
                    r_scnt <= r_scnt + 1'b1;
                    if (r_scnt == SqCntW'(RadW - 1)) begin
                        r_state <= S_OUT;
                        m_axis_tvalid <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        r_state <= S_LOAD;
                        r_count <= '0;
                        r_sum[0] <= '0; r_sum[1] <= '0; r_sum[2] <= '0;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tdata = {7'd0, r_root[16:0], r_ctr[2], r_ctr[1], r_ctr[0]};
endmodule
`default_nettype wire

// ===== tb/bounding_sphere_from_points_tb.sv =====
// Testbench for bounding_sphere_from_points: drives random and directed point sets,
// predicts center and radius per set, and checks every result word.
// Depends on bsp_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none
module bounding_sphere_from_points_tb
    import bsp_pkg::*;
();

    typedef struct packed {
        logic        last;
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } point_t;

    typedef struct packed {
        logic [16:0] radius;
        logic [15:0] cz;
        logic [15:0] cy;
        logic [15:0] cx;
    } sphere_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;    // point_x, point_y, point_z from bit 0 up
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;    // center_x, center_y, center_z, radius from bit 0 up

    bounding_sphere_from_points u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Points waiting to be sent, and spheres waiting to be seen.
    point_t  pending_points[$];
    sphere_t expected_spheres[$];

    // Predictor state: the points of the open set and their per-axis sums.
    logic signed [15:0] set_x[$];
    logic signed [15:0] set_y[$];
    logic signed [15:0] set_z[$];
    longint sum_x, sum_y, sum_z;

    int  errors = 0;
    int  idle_cycles = 0;
    bit  hold_sender = 0;      // while set, the sender starts no new set
    int  rx_hold = 0;          // long receiver stall, counted down by the monitor

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint isqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    // Feeds one accepted point into the predictor. Points past MaxPoints are
    // dropped, but a last mark on one still closes the set.
    task automatic predict_point(point_t p);
        longint cx, cy, cz, d, d2, best;
        sphere_t s;
        if (set_x.size() < MaxPoints) begin
            set_x.push_back(p.x);
            set_y.push_back(p.y);
            set_z.push_back(p.z);
            sum_x += longint'($signed(p.x));
            sum_y += longint'($signed(p.y));
            sum_z += longint'($signed(p.z));
        end
        if (p.last) begin
            // SystemVerilog integer division truncates toward zero, as required.
            cx = sum_x / set_x.size();
            cy = sum_y / set_x.size();
            cz = sum_z / set_x.size();
            best = 0;
            foreach (set_x[i]) begin
                d = longint'(set_x[i]) - cx;
                d2 = d * d;
                d = longint'(set_y[i]) - cy;
                d2 += d * d;
                d = longint'(set_z[i]) - cz;
                d2 += d * d;
                if (d2 > best) best = d2;
            end
            s.cx = cx[15:0];
            s.cy = cy[15:0];
            s.cz = cz[15:0];
            s.radius = 17'(isqrt(best));
            expected_spheres.push_back(s);
            set_x.delete();
            set_y.delete();
            set_z.delete();
            sum_x = 0;
            sum_y = 0;
            sum_z = 0;
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 600) - 300);
            default: return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 3))
                                                 : 16'h8000 + 16'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic queue_point(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic last);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.last = last;
        pending_points.push_back(p);
    endtask

    // Queues one set of n points whose coordinates all use one value style.
    task automatic queue_set(int n, int mode);
        for (int i = 0; i < n; i++)
            queue_point(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == n - 1);
    endtask

    // Driver: offers the head of the queue, with random gaps between words.
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_point(pending_points.pop_front());
                tx_gap = gap_len();
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_points.size() > 0 &&
                             !(hold_sender && set_x.size() == 0)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {pending_points[0].z, pending_points[0].y,
                                      pending_points[0].x};
                    s_axis_tlast  <= pending_points[0].last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted sphere and stalls the output at random.
    int rx_gap = 0;
    always @(posedge i_clk) begin
        sphere_t got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[64:0];
                if (expected_spheres.size() == 0) begin
                    $display("%0t: unexpected sphere %h", $time, got);
                    errors++;
                end else begin
                    want = expected_spheres.pop_front();
                    if (got.cx !== want.cx)
                        $display("%0t: center_x expected %h got %h", $time, want.cx, got.cx);
                    if (got.cy !== want.cy)
                        $display("%0t: center_y expected %h got %h", $time, want.cy, got.cy);
                    if (got.cz !== want.cz)
                        $display("%0t: center_z expected %h got %h", $time, want.cz, got.cz);
                    if (got.radius !== want.radius)
                        $display("%0t: radius expected %h got %h", $time, want.radius,
                                 got.radius);
                    if (got !== want) errors++;
                end
                rx_gap = gap_len();
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: the longest legal quiet stretch is a full set's drain plus stalls.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int n;
        int r;
        i_rst_n = 1'b0;
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single-point sets at the extremes, mixed signs, a
        // truncation toward zero on negative sums, and a tiny set.
        queue_point(16'h7fff, 16'h8000, 16'h0000, 1'b1);
        queue_point(16'h8000, 16'h7fff, 16'hffff, 1'b1);
        queue_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        queue_point(16'h8000, 16'h8000, 16'h8000, 1'b1);
        queue_point(16'hffff, 16'h0001, 16'hfffe, 1'b0);
        queue_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_point(16'h0000, 16'h0000, 16'h0001, 1'b1);
        queue_point(16'h8000, 16'h7fff, 16'h8000, 1'b0);
        queue_point(16'h7fff, 16'h8000, 16'h7fff, 1'b1);
        queue_set(5, 2);
        queue_set(3, 1);

        // A set larger than the store: the extra points must be ignored,
        // and the last mark on an ignored point still closes the set.
        queue_set(MaxPoints + 5, 0);

        // Random sets, mostly small.
        while (pending_points.size() < 1350) begin
            r = $urandom_range(0, 99);
            n = (r < 80) ? $urandom_range(1, 12) : (r < 97) ? $urandom_range(13, 60)
                                                            : $urandom_range(100, 200);
            queue_set(n, $urandom_range(0, 2));
        end

        // Long output stall while the sender keeps offering points.
        wait (pending_points.size() < 250);
        rx_hold = 3000;

        // Sender pauses at a set boundary until every expected sphere has come.
        wait (pending_points.size() < 100);
        @(posedge i_clk);
        hold_sender = 1'b1;
        wait (expected_spheres.size() == 0 && set_x.size() == 0 && !s_axis_tvalid);
        repeat (50) @(posedge i_clk);
        hold_sender = 1'b0;

        wait (pending_points.size() == 0 && !s_axis_tvalid);
        wait (expected_spheres.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
